FILE: rtl/core/stq_pkg.sv
// Shared types, codes and default sizes for the sorted timer queue scheduler.
`default_nettype none

package stq_pkg;

  // Default sizes handed to the top-level parameters
  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned ID_BITS_DEF   = 16;

  // Request codes
  typedef enum logic [1:0] {
    FUNC_TICK      = 2'd0,
    FUNC_PERIODIC  = 2'd1,
    FUNC_ONE_SHOT  = 2'd2,
    FUNC_CANCEL    = 2'd3
  } func_e;

  // Result codes
  typedef enum logic [2:0] {
    KIND_ASSIGNED = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_CANCEL   = 3'd2,
    KIND_FIRED    = 3'd3,
    KIND_NONE     = 3'd4
  } kind_e;

  // Request word
  typedef struct packed {
    func_e       func;
    logic [31:0] time_value;
    logic [15:0] cancel_id;
  } stq_req_t;

  // Result word
  typedef struct packed {
    kind_e       kind;
    logic [15:0] task_id;
    logic        found;
    logic        last;
  } stq_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/stq_alu.sv
// Shared saturating adder and less-or-equal comparator for time values.
`default_nettype none

module stq_alu #(
  parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  wire logic [TIME_BITS-1:0] a_i,
  input  wire logic [TIME_BITS-1:0] b_i,
  output logic      [TIME_BITS-1:0] sum_o,
  output logic                      le_o
);

  logic [TIME_BITS:0] raw_sum;

  // Add with carry out, clamp to all ones on overflow
  assign raw_sum = {1'b0, a_i} + {1'b0, b_i};
  assign sum_o   = raw_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : raw_sum[TIME_BITS-1:0];

  // Compare for the sorted walk
  assign le_o = (a_i <= b_i);

endmodule

`default_nettype wire

FILE: rtl/core/stq_ram.sv
// Timer table storage: one write port, one registered read port.
`default_nettype none

module stq_ram #(
  parameter int unsigned DEPTH = stq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = 2 * stq_pkg::TIME_BITS_DEF + 1 + stq_pkg::ID_BITS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_timer_queue_scheduler.sv
// Top level of the sorted timer queue scheduler: sequencer, table and shared unit.
//
// Usage: drive req_i and raise start while busy is low; the request word is
// taken at that edge. Requests: tick, schedule periodic, schedule one-shot,
// cancel by id. Each result word is on res_o for one cycle with res_valid_o
// high; the receiver cannot stall it. The final result of a request has last = 1.
// The sorted table is a memory with one write port and a registered read port;
// each walk step is a read, then a compare or move. A schedule walks back from
// the end and places the new timer after every entry due no later; if the table
// is full it answers with a table-full word and the block stays idle. A cancel
// searches the table for the id. A tick advances the time and scans the due
// timers, and answers with a none word if nothing is due; else each fired timer
// is taken off the head, its word is sent, and a periodic one is re-inserted
// behind the timers that are still due.
// One request is worked on at a time; busy stays high until its work ends.
// Reset clears the timer count, the current time and the id counter; table
// contents are left as they are and need no clearing pass.
`default_nettype none

module sorted_timer_queue_scheduler #(
  parameter int unsigned CAPACITY  = stq_pkg::CAPACITY_DEF,
  parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = stq_pkg::ID_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire stq_pkg::stq_req_t req_i,
  output logic                  res_valid_o,
  output stq_pkg::stq_rsp_t     res_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = 2 * TIME_BITS + 1 + ID_BITS;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_INS_RD    = 12'b0000_0000_0010,
    S_INS_CMP   = 12'b0000_0000_0100,
    S_CAN_RD    = 12'b0000_0000_1000,
    S_CAN_CHK   = 12'b0000_0001_0000,
    S_SCAN_RD   = 12'b0000_0010_0000,
    S_SCAN_CHK  = 12'b0000_0100_0000,
    S_SCAN_END  = 12'b0000_1000_0000,
    S_FIRE_RD   = 12'b0001_0000_0000,
    S_FIRE_HEAD = 12'b0010_0000_0000,
    S_SHF_RD    = 12'b0100_0000_0000,
    S_SHF_WR    = 12'b1000_0000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [ID_BITS-1:0]    nid_q, nid_d;
  stq_pkg::func_e        op_q, op_d;
  logic [TIME_BITS-1:0]  key_q, key_d;
  logic [TIME_BITS-1:0]  iv_q, iv_d;
  logic                  per_q, per_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         pend_q, pend_d;
  logic                  hit_q, hit_d;
  logic                  res_valid_q;
  stq_pkg::stq_rsp_t     res_q, res_d;
  logic                  emit;

  // Table port and entry fields
  logic                  we;
  logic [IW-1:0]         waddr, raddr;
  logic [EW-1:0]         wdata, rdata, new_entry;
  logic [TIME_BITS-1:0]  rd_due, rd_iv;
  logic                  rd_per;
  logic [ID_BITS-1:0]    rd_id;

  // Shared unit
  logic [TIME_BITS-1:0]  alu_a, alu_b, alu_sum;
  logic                  alu_le;

  // Request fields at internal widths
  logic [TIME_BITS+31:0] tv_ext;
  logic [TIME_BITS-1:0]  tv;
  logic [ID_BITS+15:0]   cid_ext;
  logic [ID_BITS-1:0]    cid;
  logic [ID_BITS+15:0]   id_q_ext, rd_id_ext;

  logic [CW-1:0]         ptr_m1;
  logic                  ins_done;

  assign tv_ext    = {{TIME_BITS{1'b0}}, req_i.time_value};
  assign tv        = tv_ext[TIME_BITS-1:0];
  assign cid_ext   = {{ID_BITS{1'b0}}, req_i.cancel_id};
  assign cid       = cid_ext[ID_BITS-1:0];

  assign rd_due    = rdata[EW-1 -: TIME_BITS];
  assign rd_iv     = rdata[EW-1-TIME_BITS -: TIME_BITS];
  assign rd_per    = rdata[ID_BITS];
  assign rd_id     = rdata[ID_BITS-1:0];
  assign new_entry = {key_q, iv_q, per_q, id_q};

  assign id_q_ext  = {16'b0, id_q};
  assign rd_id_ext = {16'b0, rd_id};
  assign ptr_m1    = ptr_q - 1'b1;

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  stq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stq_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .le_o  (alu_le)
  );

  // Pick operands for the shared unit
  always_comb begin
    alu_a = rd_due;
    alu_b = key_q;
    if (state_q == S_IDLE) begin
      alu_a = now_q;
      alu_b = (req_i.func == stq_pkg::FUNC_TICK) ? TIME_BITS'(1) : tv;
    end else if (state_q == S_FIRE_HEAD) begin
      alu_b = (rd_iv == '0) ? TIME_BITS'(1) : rd_iv;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    cnt_d    = cnt_q;
    nid_d    = nid_q;
    op_d     = op_q;
    key_d    = key_q;
    iv_d     = iv_q;
    per_d    = per_q;
    id_d     = id_q;
    ptr_d    = ptr_q;
    pend_d   = pend_q;
    hit_d    = hit_q;
    we       = 1'b0;
    waddr    = ptr_q[IW-1:0];
    wdata    = rdata;
    raddr    = ptr_q[IW-1:0];
    emit     = 1'b0;
    res_d    = '{kind: stq_pkg::KIND_NONE, task_id: 16'd0, found: 1'b0, last: 1'b1};
    ins_done = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d = req_i.func;
          unique case (req_i.func)
            stq_pkg::FUNC_TICK: begin
              now_d   = alu_sum;
              key_d   = alu_sum;
              ptr_d   = '0;
              state_d = S_SCAN_RD;
            end
            stq_pkg::FUNC_PERIODIC, stq_pkg::FUNC_ONE_SHOT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                emit       = 1'b1;
                res_d.kind = stq_pkg::KIND_FULL;
              end else begin
                per_d   = (req_i.func == stq_pkg::FUNC_PERIODIC);
                key_d   = (req_i.func == stq_pkg::FUNC_PERIODIC) ? alu_sum : tv;
                iv_d    = (req_i.func == stq_pkg::FUNC_PERIODIC) ? tv : '0;
                id_d    = nid_q;
                nid_d   = nid_q + 1'b1;
                ptr_d   = cnt_q;
                pend_d  = '0;
                state_d = S_INS_RD;
              end
            end
            stq_pkg::FUNC_CANCEL: begin
              id_d    = cid;
              ptr_d   = '0;
              hit_d   = 1'b0;
              state_d = S_CAN_RD;
            end
          endcase
        end
      end

      // Walk back from the end, moving later-due entries up one slot
      S_INS_RD: begin
        if (ptr_q == pend_q) begin
          ins_done = 1'b1;
        end else begin
          raddr   = ptr_m1[IW-1:0];
          state_d = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        if (alu_le) begin
          ins_done = 1'b1;
        end else begin
          we      = 1'b1;
          ptr_d   = ptr_m1;
          state_d = S_INS_RD;
        end
      end

      // Search for the id, then close the gap behind it
      S_CAN_RD: begin
        if (ptr_q == cnt_q) begin
          emit          = 1'b1;
          res_d.kind    = stq_pkg::KIND_CANCEL;
          res_d.task_id = id_q_ext[15:0];
          res_d.found   = hit_q;
          if (hit_q) begin
            cnt_d = cnt_q - 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          state_d = S_CAN_CHK;
        end
      end

      S_CAN_CHK: begin
        if (hit_q) begin
          we    = 1'b1;
          waddr = ptr_m1[IW-1:0];
        end else if (rd_id == id_q) begin
          hit_d = 1'b1;
        end
        ptr_d   = ptr_q + 1'b1;
        state_d = S_CAN_RD;
      end

      // Count the due prefix of the table
      S_SCAN_RD: begin
        if (ptr_q == cnt_q) begin
          state_d = S_SCAN_END;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (alu_le) begin
          ptr_d   = ptr_q + 1'b1;
          state_d = S_SCAN_RD;
        end else begin
          state_d = S_SCAN_END;
        end
      end

      S_SCAN_END: begin
        pend_d = ptr_q;
        if (ptr_q == '0) begin
          emit       = 1'b1;
          res_d.kind = stq_pkg::KIND_NONE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_FIRE_RD;
        end
      end

      // Take the next due timer from the head
      S_FIRE_RD: begin
        if (pend_q == '0) begin
          state_d = S_IDLE;
        end else begin
          raddr   = '0;
          state_d = S_FIRE_HEAD;
        end
      end

      S_FIRE_HEAD: begin
        emit          = 1'b1;
        res_d.kind    = stq_pkg::KIND_FIRED;
        res_d.task_id = rd_id_ext[15:0];
        res_d.last    = (pend_q == CW'(1));
        key_d         = alu_sum;
        iv_d          = rd_iv;
        per_d         = rd_per;
        id_d          = rd_id;
        ptr_d         = CW'(1);
        state_d       = S_SHF_RD;
      end

      // Shift the rest down over the removed head
      S_SHF_RD: begin
        if (ptr_q == cnt_q) begin
          cnt_d  = cnt_q - 1'b1;
          pend_d = pend_q - 1'b1;
          if (per_q) begin
            ptr_d   = cnt_q - 1'b1;
            state_d = S_INS_RD;
          end else begin
            state_d = S_FIRE_RD;
          end
        end else begin
          state_d = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        we      = 1'b1;
        waddr   = ptr_m1[IW-1:0];
        ptr_d   = ptr_q + 1'b1;
        state_d = S_SHF_RD;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Place the new entry and finish the insert
    if (ins_done) begin
      we    = 1'b1;
      wdata = new_entry;
      cnt_d = cnt_q + 1'b1;
      if (op_q == stq_pkg::FUNC_TICK) begin
        state_d = S_FIRE_RD;
      end else begin
        emit          = 1'b1;
        res_d.kind    = stq_pkg::KIND_ASSIGNED;
        res_d.task_id = id_q_ext[15:0];
        state_d       = S_IDLE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      cnt_q       <= '0;
      nid_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      cnt_q       <= cnt_d;
      nid_q       <= nid_d;
      res_valid_q <= emit;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    iv_q   <= iv_d;
    per_q  <= per_d;
    id_q   <= id_d;
    ptr_q  <= ptr_d;
    pend_q <= pend_d;
    hit_q  <= hit_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stq_chk.sv
// Port-level checks for the sorted timer queue scheduler, bound to the top level.
`default_nettype none

module stq_chk (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              res_valid_o,
  input wire stq_pkg::stq_rsp_t res_o
);

  // An accepted word either starts work or answers at once
  a_accept_acts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o)
    else $error("accepted word neither started work nor answered");

  // Busy only rises after a word was taken
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  // Only fired timers come in runs; a non-final word keeps the block busy
  a_run_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy && res_o.kind == stq_pkg::KIND_FIRED)
    else $error("non-final result outside a fired run");

  // A refused schedule carries no id and no found flag
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == stq_pkg::KIND_FULL |->
      res_o.task_id == 16'd0 && !res_o.found && res_o.last && !busy)
    else $error("table-full result malformed");

  // Found is only set on cancel answers
  a_found_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.found |-> res_o.kind == stq_pkg::KIND_CANCEL)
    else $error("found set on a result that is not a cancel answer");

endmodule

bind sorted_timer_queue_scheduler stq_chk u_stq_chk (.*);

`default_nettype wire

FILE: sim/tb_sorted_timer_queue_scheduler.sv
// Self-checking testbench for the sorted timer queue scheduler, with its own timer-table model.
module tb_sorted_timer_queue_scheduler;
  import stq_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 200;

  typedef struct {
    stq_req_t req;
    bit       drain;
  } pending_word_t;

  logic     clk_i    = 1'b0;
  logic     rst_ni   = 1'b0;
  logic     start    = 1'b0;
  stq_req_t req_word = '0;
  logic     busy;
  logic     res_valid;
  stq_rsp_t res_word;

  pending_word_t pending_words[$];
  stq_rsp_t      expected_words[$];

  // Timer table model
  logic [31:0] tbl_due  [CAP];
  logic [31:0] tbl_iv   [CAP];
  logic        tbl_per  [CAP];
  logic [15:0] tbl_id   [CAP];
  int          tbl_count   = 0;
  logic [31:0] now_time    = '0;
  logic [15:0] next_id     = '0;

  int items_taken   = 0;
  int items_popped  = 0;
  int words_checked = 0;
  int mismatches    = 0;
  int fired_seen    = 0;
  int full_seen     = 0;
  int cancel_hits   = 0;
  int idle_cycles   = 0;

  sorted_timer_queue_scheduler u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_word),
    .res_valid_o(res_valid),
    .res_o      (res_word)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [31:0] due_sum_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic stq_rsp_t make_word(input kind_e k, input logic [15:0] id,
                                         input logic f, input logic l);
    stq_rsp_t w;
    w.kind    = k;
    w.task_id = id;
    w.found   = f;
    w.last    = l;
    return w;
  endfunction

  // Insert after every entry with due time <= due
  task automatic timer_insert(input logic [31:0] due, input logic [31:0] iv,
                              input logic per, input logic [15:0] id);
    int pos;
    int i;
    pos = 0;
    while (pos < tbl_count && tbl_due[pos] <= due) pos++;
    for (i = tbl_count; i > pos; i--) begin
      tbl_due[i] = tbl_due[i-1];
      tbl_iv[i]  = tbl_iv[i-1];
      tbl_per[i] = tbl_per[i-1];
      tbl_id[i]  = tbl_id[i-1];
    end
    tbl_due[pos] = due;
    tbl_iv[pos]  = iv;
    tbl_per[pos] = per;
    tbl_id[pos]  = id;
    tbl_count++;
  endtask

  task automatic timer_remove(input int pos);
    int i;
    for (i = pos; i + 1 < tbl_count; i++) begin
      tbl_due[i] = tbl_due[i+1];
      tbl_iv[i]  = tbl_iv[i+1];
      tbl_per[i] = tbl_per[i+1];
      tbl_id[i]  = tbl_id[i+1];
    end
    tbl_count--;
  endtask

  // Work out the result words of one request and queue them
  task automatic compute_timer_results(input stq_req_t r);
    logic [31:0] f_due [CAP];
    logic [31:0] f_iv  [CAP];
    logic        f_per [CAP];
    logic [15:0] f_id  [CAP];
    int          d;
    int          i;
    logic        hit;
    case (r.func)
      FUNC_PERIODIC, FUNC_ONE_SHOT: begin
        if (tbl_count >= CAP) begin
          expected_words.push_back(make_word(KIND_FULL, '0, 1'b0, 1'b1));
        end else begin
          if (r.func == FUNC_PERIODIC)
            timer_insert(due_sum_sat(now_time, r.time_value), r.time_value, 1'b1, next_id);
          else
            timer_insert(r.time_value, '0, 1'b0, next_id);
          expected_words.push_back(make_word(KIND_ASSIGNED, next_id, 1'b0, 1'b1));
          next_id = next_id + 16'd1;
        end
      end
      FUNC_CANCEL: begin
        hit = 1'b0;
        for (i = 0; i < tbl_count; i++) begin
          if (!hit && tbl_id[i] == r.cancel_id) begin
            timer_remove(i);
            hit = 1'b1;
          end
        end
        expected_words.push_back(make_word(KIND_CANCEL, r.cancel_id, hit, 1'b1));
      end
      default: begin
        // Advance time, take every due timer off the head, re-arm periodic ones
        now_time = due_sum_sat(now_time, 32'd1);
        d = 0;
        while (d < tbl_count && tbl_due[d] <= now_time) begin
          f_due[d] = tbl_due[d];
          f_iv[d]  = tbl_iv[d];
          f_per[d] = tbl_per[d];
          f_id[d]  = tbl_id[d];
          d++;
        end
        if (d == 0) begin
          expected_words.push_back(make_word(KIND_NONE, '0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i < d; i++) timer_remove(0);
          for (i = 0; i < d; i++) begin
            expected_words.push_back(make_word(KIND_FIRED, f_id[i], 1'b0, i == d - 1));
            if (f_per[i])
              timer_insert(due_sum_sat(f_due[i], (f_iv[i] == 0) ? 32'd1 : f_iv[i]),
                           f_iv[i], 1'b1, f_id[i]);
          end
        end
      end
    endcase
  endtask

  // Monitor: check result words, then predict for a newly taken request word
  always @(posedge clk_i) begin
    stq_rsp_t want;
    if (rst_ni) begin
      if (res_valid === 1'b1) begin
        words_checked++;
        if (res_word.kind == KIND_FIRED) fired_seen++;
        if (res_word.kind == KIND_FULL) full_seen++;
        if (res_word.kind == KIND_CANCEL && res_word.found) cancel_hits++;
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: kind=%0d id=%0d found=%0d last=%0d",
                     res_word.kind, res_word.task_id, res_word.found, res_word.last);
          mismatches++;
        end else begin
          want = expected_words[0];
          expected_words.delete(0);
          if (res_word.kind !== want.kind || res_word.task_id !== want.task_id ||
              res_word.found !== want.found || res_word.last !== want.last) begin
            if (mismatches < 10) begin
              $display("result word %0d: expected kind=%0d id=%0d found=%0d last=%0d,",
                       words_checked, want.kind, want.task_id, want.found, want.last);
              $display("  got kind=%0d id=%0d found=%0d last=%0d",
                       res_word.kind, res_word.task_id, res_word.found, res_word.last);
            end
            mismatches++;
          end
        end
      end
      if (start && busy === 1'b0) begin
        compute_timer_results(req_word);
        items_taken++;
      end
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all
  always @(posedge clk_i) begin
    if (rst_ni && (res_valid === 1'b1 || (start && busy === 1'b0)))
      idle_cycles = 0;
    else if (rst_ni)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Driver: offer the head request word, drop it once taken
  always @(negedge clk_i) begin
    bit offering;
    bit quiet;
    if (!rst_ni) begin
      start <= 1'b0;
      offering = 1'b0;
    end else begin
      if (items_taken != items_popped) begin
        pending_words.delete(0);
        items_popped++;
        offering = 1'b0;
      end
      if (!offering) begin
        quiet = (items_popped < 60 || items_popped > 95) && ($urandom_range(0, 99) < 16);
        if (pending_words.size() == 0 || quiet ||
            (pending_words[0].drain && expected_words.size() != 0)) begin
          start <= 1'b0;
        end else begin
          start    <= 1'b1;
          req_word <= pending_words[0].req;
          offering = 1'b1;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int gen_ticks;
    int gen_scheds;
    int k;
    int pick;
    logic [31:0] tv;
    logic [15:0] cid;

    gen_ticks  = 0;
    gen_scheds = 0;

    // Directed: empty table, extremes, equal due times, cancel hit and miss
    queue_word(FUNC_TICK, $urandom, $urandom, 1'b0); gen_ticks++;
    queue_word(FUNC_CANCEL, $urandom, 16'hFFFF, 1'b0);
    queue_word(FUNC_ONE_SHOT, 32'd0, $urandom, 1'b0);
    queue_word(FUNC_PERIODIC, 32'd0, $urandom, 1'b0);
    queue_word(FUNC_PERIODIC, 32'hFFFF_FFFF, 16'd0, 1'b0);
    queue_word(FUNC_ONE_SHOT, 32'hFFFF_FFFF, 16'd0, 1'b0);
    queue_word(FUNC_ONE_SHOT, 32'd5, 16'd0, 1'b0);
    queue_word(FUNC_ONE_SHOT, 32'd5, 16'd0, 1'b0);
    queue_word(FUNC_PERIODIC, 32'd3, 16'd0, 1'b0);
    gen_scheds = 7;
    queue_word(FUNC_TICK, $urandom, $urandom, 1'b0); gen_ticks++;
    queue_word(FUNC_CANCEL, 32'hFFFF_FFFF, 16'd2, 1'b0);
    queue_word(FUNC_CANCEL, 32'd0, 16'd2, 1'b0);
    // Fill the table, then ask twice more
    for (k = 0; k < 11; k++) begin
      if (k[0]) queue_word(FUNC_PERIODIC, $urandom_range(0, 5), $urandom, 1'b0);
      else      queue_word(FUNC_ONE_SHOT, $urandom_range(2, 12), $urandom, 1'b0);
      gen_scheds++;
    end
    queue_word(FUNC_PERIODIC, 32'd1, $urandom, 1'b0);
    queue_word(FUNC_ONE_SHOT, 32'd1, $urandom, 1'b0);

    // Random: mostly near-term timers so they fire, plus some wide values
    for (k = 0; k < 110; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_word(FUNC_TICK, $urandom, $urandom, (k == 0) || (k == 50));
        gen_ticks++;
      end else if (pick < 60) begin
        pick = $urandom_range(0, 9);
        tv = (pick < 1) ? 32'd0 : (pick < 8) ? $urandom_range(0, 6) : $urandom;
        queue_word(FUNC_PERIODIC, tv, $urandom, (k == 0) || (k == 50));
        gen_scheds++;
      end else if (pick < 80) begin
        tv = ($urandom_range(0, 3) != 0) ? gen_ticks + $urandom_range(0, 10) : $urandom;
        queue_word(FUNC_ONE_SHOT, tv, $urandom, (k == 0) || (k == 50));
        gen_scheds++;
      end else begin
        cid = ($urandom_range(0, 9) < 7) ? $urandom_range(0, gen_scheds + 1) : $urandom;
        queue_word(FUNC_CANCEL, $urandom, cid, (k == 0) || (k == 50));
      end
    end

    // Reset
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Hold until every word is taken and answered, then watch for stray results
    wait (pending_words.size() == 0);
    wait (expected_words.size() == 0);
    repeat (TAIL_WAIT) @(posedge clk_i);

    $display("%0d requests taken, %0d result words checked", items_taken, words_checked);
    $display("%0d timers fired, %0d table-full answers, %0d cancels hit",
             fired_seen, full_seen, cancel_hits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  task automatic queue_word(input func_e f, input logic [31:0] tv, input logic [15:0] cid,
                            input bit drain);
    pending_word_t p;
    p.req.func       = f;
    p.req.time_value = tv;
    p.req.cancel_id  = cid;
    p.drain          = drain;
    pending_words.push_back(p);
  endtask

endmodule
